[src/plrl_pkg.sv]
// ----------------------------------------------------------------------------
// plrl_pkg
// Shared types and constants for the PLL synthesizer register loader.
// ----------------------------------------------------------------------------
package plrl_pkg;

    localparam int WORD_W    = 32;
    localparam int FREQ_W    = 16;
    localparam int REFDIV_W  = 10;
    localparam int IDX_W     = 3;
    localparam int BITCNT_W  = 6;
    localparam int FW_SHIFT  = 15;
    localparam int REFDIV_SH = 14;

    localparam logic [REFDIV_W-1:0] REFDIV_RESET = 10'd125;

    // opcodes
    localparam logic OP_INIT     = 1'b0;
    localparam logic OP_SET_FREQ = 1'b1;

    // position of the last word in each command
    localparam logic [IDX_W-1:0] INIT_LAST_IDX = 3'd5;
    localparam logic [IDX_W-1:0] SETF_LAST_IDX = 3'd1;

    // init words
    localparam logic [WORD_W-1:0] INIT_W0 = 32'h0058_0005;
    localparam logic [WORD_W-1:0] INIT_W1 = 32'h0060_a43c;
    localparam logic [WORD_W-1:0] INIT_W2 = 32'h0060_04b3;
    localparam logic [WORD_W-1:0] INIT_W3 = 32'h0D00_3FC2;
    localparam logic [WORD_W-1:0] INIT_W4 = 32'h0800_8011;

    // output divider words per frequency band
    localparam logic [WORD_W-1:0] BAND_W0   = 32'h0050_443c;
    localparam logic [WORD_W-1:0] BAND_W1   = 32'h0040_443c;
    localparam logic [WORD_W-1:0] BAND_W2   = 32'h0030_143c;
    localparam logic [WORD_W-1:0] BAND_W3   = 32'h0020_143c;
    localparam logic [WORD_W-1:0] BAND_W4   = 32'h0010_143c;
    localparam logic [WORD_W-1:0] BAND_W5   = 32'h0000_143c;
    localparam logic [WORD_W-1:0] BAND_WLOW = 32'h0060_443c;

    localparam logic [FREQ_W-1:0] BAND_LO  = 16'd690;
    localparam logic [FREQ_W-1:0] BAND_B0  = 16'd1370;
    localparam logic [FREQ_W-1:0] BAND_B1  = 16'd2740;
    localparam logic [FREQ_W-1:0] BAND_B2  = 16'd5490;
    localparam logic [FREQ_W-1:0] BAND_B3  = 16'd10990;
    localparam logic [FREQ_W-1:0] BAND_B4  = 16'd21990;

    typedef struct packed {
        logic start;
    } shift_ctrl_t;

    typedef struct packed {
        logic busy;
    } shift_stat_t;

endpackage

[src/pll_synth_register_loader.sv]
// ----------------------------------------------------------------------------
// pll_synth_register_loader
// Sequences control words for a PLL synthesizer and shifts each one out
// serially before handing it on as an output beat.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction | beat
//  in      | in_valid/in_ready, opcode,       | input     | one command
//          | freq_word                        |           |
//  out     | out_valid/out_ready,             | output    | one control word
//          | control_word, last_word          |           |
//  cfg     | cfg_we, cfg_wdata                | input     | ref divider write
//
// each word is loaded into the shifter, shifted out serially (32 bits),
// then presented once the shifter reports idle; init sends 6 words,
// set freq sends 2 words, and a word stays presented while out_ready
// is held low.
// in_ready is high only when no command is in flight.
// reset clears the sequencer and sets the ref divider to 125.
// ----------------------------------------------------------------------------
module pll_synth_register_loader (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic [plrl_pkg::FREQ_W-1:0]       freq_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [plrl_pkg::WORD_W-1:0]       control_word,
    output logic                              last_word,
    input  logic                              cfg_we,
    input  logic [plrl_pkg::REFDIV_W-1:0]     cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t                            state_reg, state_next;
    logic                              op_reg, op_next;
    logic [plrl_pkg::FREQ_W-1:0]       freq_reg, freq_next;
    logic [plrl_pkg::IDX_W-1:0]        word_index_reg, word_index_next;
    logic [plrl_pkg::REFDIV_W-1:0]     ref_div_reg;
    logic [plrl_pkg::WORD_W-1:0]       sel_word;
    logic                              is_last;
    plrl_pkg::shift_ctrl_t             sh_ctrl;
    plrl_pkg::shift_stat_t             sh_stat;

    plrl_word_sel u_word_sel (
        .opcode      (op_reg),
        .word_idx    (word_index_reg),
        .freq_word   (freq_reg),
        .ref_divider (ref_div_reg),
        .word        (sel_word)
    );

    plrl_shifter u_shifter (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (sh_ctrl),
        .load_word (sel_word),
        .stat      (sh_stat),
        .rx_word   (control_word)
    );

    assign is_last = (op_reg == plrl_pkg::OP_SET_FREQ)
                     ? (word_index_reg == plrl_pkg::SETF_LAST_IDX)
                     : (word_index_reg == plrl_pkg::INIT_LAST_IDX);

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign last_word = is_last;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        freq_next       = freq_reg;
        word_index_next = word_index_reg;
        sh_ctrl.start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = opcode;
                    freq_next       = freq_word;
                    word_index_next = '0;
                    state_next      = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                sh_ctrl.start = 1'b1;
                state_next    = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (!sh_stat.busy)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (is_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        word_index_next = word_index_reg + 1'b1;
                        state_next      = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            word_index_reg <= '0;
            op_reg         <= plrl_pkg::OP_INIT;
            ref_div_reg    <= plrl_pkg::REFDIV_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            word_index_reg <= word_index_next;
            op_reg         <= op_next;
            if (cfg_we)
                ref_div_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg <= freq_next;
    end

endmodule

[src/plrl_word_sel.sv]
// ----------------------------------------------------------------------------
// plrl_word_sel
// Picks the control word for a given command and word position.
// ----------------------------------------------------------------------------
module plrl_word_sel (
    input  logic                              opcode,
    input  logic [plrl_pkg::IDX_W-1:0]        word_idx,
    input  logic [plrl_pkg::FREQ_W-1:0]       freq_word,
    input  logic [plrl_pkg::REFDIV_W-1:0]     ref_divider,
    output logic [plrl_pkg::WORD_W-1:0]       word
);

    logic [plrl_pkg::WORD_W-1:0] fw_word;
    logic [plrl_pkg::WORD_W-1:0] band_word;
    logic [plrl_pkg::WORD_W-1:0] refdiv_word;

    assign fw_word = {{(plrl_pkg::WORD_W-plrl_pkg::FREQ_W){1'b0}}, freq_word}
                     << plrl_pkg::FW_SHIFT;
    assign refdiv_word = plrl_pkg::INIT_W3 |
        ({{(plrl_pkg::WORD_W-plrl_pkg::REFDIV_W){1'b0}}, ref_divider}
         << plrl_pkg::REFDIV_SH);

    always_comb
    begin
        if (freq_word < plrl_pkg::BAND_LO)
            band_word = plrl_pkg::BAND_WLOW;
        else if (freq_word <= plrl_pkg::BAND_B0)
            band_word = plrl_pkg::BAND_W0;
        else if (freq_word <= plrl_pkg::BAND_B1)
            band_word = plrl_pkg::BAND_W1;
        else if (freq_word <= plrl_pkg::BAND_B2)
            band_word = plrl_pkg::BAND_W2;
        else if (freq_word <= plrl_pkg::BAND_B3)
            band_word = plrl_pkg::BAND_W3;
        else if (freq_word <= plrl_pkg::BAND_B4)
            band_word = plrl_pkg::BAND_W4;
        else
            band_word = plrl_pkg::BAND_W5;
    end

    always_comb
    begin
        if (opcode == plrl_pkg::OP_SET_FREQ)
        begin
            word = (word_idx == 3'd0) ? band_word : fw_word;
        end
        else
        begin
            case (word_idx)
                3'd0:    word = plrl_pkg::INIT_W0;
                3'd1:    word = plrl_pkg::INIT_W1;
                3'd2:    word = plrl_pkg::INIT_W2;
                3'd3:    word = refdiv_word;
                3'd4:    word = plrl_pkg::INIT_W4;
                default: word = fw_word;
            endcase
        end
    end

endmodule

[src/plrl_shifter.sv]
// ----------------------------------------------------------------------------
// plrl_shifter
// Serial word shifter: one bit per serial clock period, MSB first,
// with a loopback capture register that rebuilds the sent word.
// ----------------------------------------------------------------------------
module plrl_shifter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  plrl_pkg::shift_ctrl_t         ctrl,
    input  logic [plrl_pkg::WORD_W-1:0]   load_word,
    output plrl_pkg::shift_stat_t         stat,
    output logic [plrl_pkg::WORD_W-1:0]   rx_word
);

    logic [plrl_pkg::WORD_W-1:0]   shift_data_reg, shift_data_next;
    logic [plrl_pkg::WORD_W-1:0]   rx_reg, rx_next;
    logic [plrl_pkg::BITCNT_W-1:0] bit_count_reg, bit_count_next;
    logic                          phase_reg, phase_next;
    logic                          active_reg, active_next;
    logic                          sdata;

    // serial data line
    assign sdata = shift_data_reg[plrl_pkg::WORD_W-1];

    always_comb
    begin
        shift_data_next = shift_data_reg;
        rx_next         = rx_reg;
        bit_count_next  = bit_count_reg;
        phase_next      = phase_reg;
        active_next     = active_reg;
        if (ctrl.start)
        begin
            shift_data_next = load_word;
            bit_count_next  = '0;
            phase_next      = 1'b0;
            active_next     = 1'b1;
        end
        else if (active_reg)
        begin
            phase_next = ~phase_reg;
            // rising serial clock edge
            if (phase_reg)
            begin
                rx_next         = {rx_reg[plrl_pkg::WORD_W-2:0], sdata};
                shift_data_next = {shift_data_reg[plrl_pkg::WORD_W-2:0], 1'b0};
                bit_count_next  = bit_count_reg + 1'b1;
                if (bit_count_reg == plrl_pkg::BITCNT_W'(plrl_pkg::WORD_W - 1))
                    active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_data_reg <= '0;
            bit_count_reg  <= '0;
            phase_reg      <= 1'b0;
            active_reg     <= 1'b0;
        end
        else
        begin
            shift_data_reg <= shift_data_next;
            bit_count_reg  <= bit_count_next;
            phase_reg      <= phase_next;
            active_reg     <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg <= rx_next;
    end

    assign stat.busy = active_reg;
    assign rx_word   = rx_reg;

endmodule

[test/plrl_word_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrl_word_checker
// Watches the command, control word and ref divider ports of the register
// loader, predicts the word sequence of every accepted command and compares
// each output beat against the oldest predicted word.
// ----------------------------------------------------------------------------
module plrl_word_checker
    import plrl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                opcode,
    input  logic [FREQ_W-1:0]   freq_word,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [WORD_W-1:0]   control_word,
    input  logic                last_word,
    input  logic                cfg_we,
    input  logic [REFDIV_W-1:0] cfg_wdata,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } ctrl_beat_t;

    ctrl_beat_t        expected_words[$];
    logic [REFDIV_W-1:0] ref_div_model;
    int                errs;

    function automatic logic [WORD_W-1:0] divider_word_for(input logic [FREQ_W-1:0] f);
        if (f < BAND_LO)
            return BAND_WLOW;
        else if (f <= BAND_B0)
            return BAND_W0;
        else if (f <= BAND_B1)
            return BAND_W1;
        else if (f <= BAND_B2)
            return BAND_W2;
        else if (f <= BAND_B3)
            return BAND_W3;
        else if (f <= BAND_B4)
            return BAND_W4;
        else
            return BAND_W5;
    endfunction

    task automatic queue_command_words(input logic op, input logic [FREQ_W-1:0] f);
        logic [WORD_W-1:0] freq_reg;
        freq_reg = WORD_W'(f) << FW_SHIFT;
        if (op == OP_INIT)
        begin
            expected_words.push_back('{INIT_W0, 1'b0});
            expected_words.push_back('{INIT_W1, 1'b0});
            expected_words.push_back('{INIT_W2, 1'b0});
            expected_words.push_back('{INIT_W3 | (WORD_W'(ref_div_model) << REFDIV_SH), 1'b0});
            expected_words.push_back('{INIT_W4, 1'b0});
            expected_words.push_back('{freq_reg, 1'b1});
        end
        else
        begin
            expected_words.push_back('{divider_word_for(f), 1'b0});
            expected_words.push_back('{freq_reg, 1'b1});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ctrl_beat_t want;
        if (!rst_n)
        begin
            expected_words.delete();
            ref_div_model = REFDIV_RESET;
            errs = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                ref_div_model = cfg_wdata;
            // check the output beat before queueing a command taken on the same edge
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    errs++;
                    $error("unexpected beat: control_word %h last_word %b",
                           control_word, last_word);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (control_word !== want.word)
                    begin
                        errs++;
                        $error("control_word mismatch: expected %h, actual %h",
                               want.word, control_word);
                    end
                    if (last_word !== want.last)
                    begin
                        errs++;
                        $error("last_word mismatch: expected %b, actual %b",
                               want.last, last_word);
                    end
                end
            end
            if (in_valid && in_ready)
                queue_command_words(opcode, freq_word);
            fail_count <= errs;
            pending <= expected_words.size();
        end
    end

endmodule

[test/pll_synth_register_loader_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_synth_register_loader_tb
// Drives init and set-frequency commands with random gaps and output stalls,
// reprograms the ref divider between phases, and takes the verdict from the
// word checker.
// ----------------------------------------------------------------------------
module pll_synth_register_loader_tb;
    import plrl_pkg::*;

    localparam int LIMIT        = 3_000_000;
    localparam int HOLD_CYCLES  = 800;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_ITEMS  = 90;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic                opcode       = OP_INIT;
    logic [FREQ_W-1:0]   freq_word    = '0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic [WORD_W-1:0]   control_word;
    logic                last_word;
    logic                cfg_we       = 1'b0;
    logic [REFDIV_W-1:0] cfg_wdata    = '0;

    int fail_count;
    int pending;
    int cycles;
    int n_init;
    int n_setf;
    int n_cfg;
    bit calm;
    bit hold_off_req;
    bit hold_done;

    pll_synth_register_loader dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .freq_word    (freq_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .control_word (control_word),
        .last_word    (last_word),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    plrl_word_checker u_word_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .freq_word    (freq_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .control_word (control_word),
        .last_word    (last_word),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("pll_synth_register_loader verification failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // four in ten values sit close to a band edge
    function automatic logic [FREQ_W-1:0] pick_freq();
        int edges[6] = '{690, 1371, 2741, 5491, 10991, 21991};
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return FREQ_W'($urandom_range(0, 65535));
        else if (r < 8)
            return FREQ_W'(edges[$urandom_range(0, 5)] + $urandom_range(0, 8) - 4);
        else if (r == 8)
            return FREQ_W'($urandom_range(0, 689));
        else
            return FREQ_W'($urandom_range(21991, 65535));
    endfunction

    // out_ready: mostly high, short and occasional long stalls, one forced hold-off
    initial
    begin
        int r;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_done)
            begin
                out_ready <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (calm || r < 70)
                    out_ready <= 1'b1;
                else if (r < 97)
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge clk);
                end
                else
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(20, 150)) @(posedge clk);
                end
            end
        end
    end

    task automatic send_command(input logic op, input logic [FREQ_W-1:0] f);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        freq_word <= f;
        do
            @(posedge clk);
        while (!in_ready);
        if (op == OP_INIT)
            n_init++;
        else
            n_setf++;
    endtask

    task automatic finish_phase();
        in_valid <= 1'b0;
        // let the checker count the command taken on the last edge
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_ref_divider(input logic [REFDIV_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        n_cfg++;
    endtask

    initial
    begin
        logic [FREQ_W-1:0] band_edges[14] = '{16'd0, 16'd689, 16'd690, 16'd1370, 16'd1371,
                                              16'd2740, 16'd2741, 16'd5490, 16'd5491,
                                              16'd10990, 16'd10991, 16'd21990, 16'd21991,
                                              16'hFFFF};
        n_init = 0;
        n_setf = 0;
        n_cfg  = 0;
        calm = 1'b0;
        hold_off_req = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // set frequency ahead of any init, still at the reset divider
        send_command(OP_SET_FREQ, 16'd1000);
        send_command(OP_INIT, 16'd0);
        foreach (band_edges[i])
            send_command(OP_SET_FREQ, band_edges[i]);
        send_command(OP_INIT, 16'hFFFF);
        finish_phase();

        write_ref_divider('0);
        send_command(OP_INIT, 16'h5555);
        finish_phase();
        write_ref_divider('1);
        send_command(OP_INIT, 16'hAAAA);
        finish_phase();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_ref_divider(ph == 3 ? REFDIV_RESET : REFDIV_W'($urandom_range(0, 1023)));
            calm = (ph == 1);
            if (ph == 2)
                hold_off_req = 1'b1;
            repeat (PHASE_ITEMS)
                send_command(logic'($urandom_range(0, 1)), pick_freq());
            finish_phase();
            calm = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d init and %0d set-frequency commands over %0d divider writes",
                 n_init, n_setf, n_cfg);
        $display("band edges, divider extremes and a %0d-cycle output hold-off were exercised",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("pll_synth_register_loader verification clean");
        else
            $display("pll_synth_register_loader verification failed");
        $finish;
    end

endmodule
